### design/gblur_pkg.sv
// ---------------------------------------------------------------------------
// gblur_pkg
// Shared types, constants and the tap-sum function of the 3x3 blur stream.
// ---------------------------------------------------------------------------
package gblur_pkg;

  // sizes and widths
  localparam int MAX_SIZE_DEF = 2048;
  localparam int PIX_W        = 8;
  localparam int CFG_W        = 12;
  localparam int CFG_RESET    = 16;
  localparam int MIN_SIZE     = 2;
  localparam int SUM_W        = 12;
  localparam int LINE_W       = 2 * PIX_W;

  // divide by nine through a reciprocal, exact for sums below 32768
  localparam int                 RECIP_W    = 13;
  localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;
  localparam int                 DIV9_SHIFT = 16;
  localparam int                 PROD_W     = SUM_W + RECIP_W;

  // result queue
  localparam int OFIFO_DEPTH = 16;
  localparam int FIFO_AW     = $clog2(OFIFO_DEPTH);
  localparam int LVL_W       = FIFO_AW + 1;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_t;

  typedef logic [PIX_W-1:0] pix_t;

  // window indexed [column][row]; column 2 is the newest, row 2 the lowest
  typedef logic [2:0][2:0][PIX_W-1:0] window_t;

  // which results an item makes and where they sit in the image
  typedef struct packed {
    logic emit_a;   // result for the column before the newest
    logic emit_b;   // result for the last column
    logic x_first;  // emit_a result is in column zero
    logic y_first;  // results are in the top row
    logic y_last;   // results are in the bottom row
  } emit_meta_t;

  typedef struct packed {
    logic             corner;
    logic [SUM_W-1:0] sum;
  } tap_t;

  typedef struct packed {
    pix_t pixel_out;
    logic row_end;
    logic frame_end;
    logic run_last;
  } result_t;

  // results handed to the output queue in one cycle
  typedef struct packed {
    logic [1:0] cnt;
    result_t    first;
    result_t    second;
    logic       busy;
  } push_t;

  // weighted sum around centre column cc, edges replicated, corner rule
  function automatic tap_t tap_sum(window_t w, logic [1:0] cc, logic x_first,
                                   logic x_last, logic y_first, logic y_last);
    logic [1:0] lc;
    logic [1:0] rc;
    logic [1:0] tr;
    logic [1:0] br;
    logic [1:0] hc;
    logic [1:0] vr;
    tap_t       t;
    lc = x_first ? cc : cc - 2'd1;
    rc = (x_last || cc == 2'd2) ? cc : cc + 2'd1;
    tr = y_first ? 2'd1 : 2'd0;
    br = y_last ? 2'd1 : 2'd2;
    hc = x_first ? cc + 2'd1 : cc - 2'd1;
    vr = y_first ? 2'd2 : 2'd0;
    t.corner = (x_first || x_last) && (y_first || y_last);
    if (t.corner) begin
      t.sum = (SUM_W'(w[cc][1]) << 2) + (SUM_W'(w[hc][1]) << 1)
            + (SUM_W'(w[cc][vr]) << 1) + SUM_W'(w[hc][vr]);
    end else begin
      t.sum = SUM_W'(w[lc][tr]) + (SUM_W'(w[cc][tr]) << 1) + SUM_W'(w[rc][tr])
            + (SUM_W'(w[lc][1]) << 1) + (SUM_W'(w[cc][1]) << 2)
            + (SUM_W'(w[rc][1]) << 1)
            + SUM_W'(w[lc][br]) + (SUM_W'(w[cc][br]) << 1) + SUM_W'(w[rc][br]);
    end
    return t;
  endfunction

endpackage

### design/gblur_ifs.sv
// ---------------------------------------------------------------------------
// gblur channel interfaces
// Valid/ready channels for pixel items, results and the size register.
// ---------------------------------------------------------------------------
interface gblur_in_if import gblur_pkg::*; ();
  logic valid;
  logic ready;
  logic opcode;
  pix_t pixel_in;

  modport source (output valid, output opcode, output pixel_in, input ready);
  modport sink   (input valid, input opcode, input pixel_in, output ready);
endinterface

interface gblur_out_if import gblur_pkg::*; ();
  logic valid;
  logic ready;
  pix_t pixel_out;
  logic row_end;
  logic frame_end;
  logic run_last;

  modport source (output valid, output pixel_out, output row_end, output frame_end,
                  output run_last, input ready);
  modport sink   (input valid, input pixel_out, input row_end, input frame_end,
                  input run_last, output ready);
endinterface

interface gblur_cfg_if import gblur_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] image_size;

  modport source (output valid, output image_size, input ready);
  modport sink   (input valid, input image_size, output ready);
endinterface

### design/gaussian_blur_3x3_stream.sv
// ---------------------------------------------------------------------------
// gaussian_blur_3x3_stream
// Streaming 3x3 Gaussian blur of a square 8-bit image with one two-row line buffer.
// ---------------------------------------------------------------------------
//  channel | dir | payload                                   | transfer
//  in_ch   | in  | opcode, pixel_in                          | valid & ready
//  out_ch  | out | pixel_out, row_end, frame_end, run_last   | valid & ready
//  cfg_ch  | in  | image_size                                | valid & ready
//
//  One item per cycle while ready holds; the line buffer (one read, one write
//  port) is read on the transfer and written back in the next cycle. Results
//  pass the read-data, window and sum registers into the 16-entry queue.
//  A last-column item makes two results, so ready drops while the queue lacks
//  room for every item in flight. Reset is synchronous and needs no clearing
//  pass: line buffer entries are written before any result depends on them.
// ---------------------------------------------------------------------------
module gaussian_blur_3x3_stream import gblur_pkg::*; #(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  gblur_in_if.sink      in_ch,
  gblur_out_if.source   out_ch,
  gblur_cfg_if.sink     cfg_ch
);

  localparam int CW = $clog2(MAX_SIZE);
  localparam int RW = CW + 1;
  localparam int EW = (RW > CFG_W) ? RW : CFG_W;

  // size register
  logic [RW-1:0] size_r;
  logic [RW-1:0] size_m1_r;
  logic [RW-1:0] size_nxt;
  logic [EW-1:0] cfg_ext;
  logic          cfg_xfer;

  // frame position
  logic [CW-1:0] col_r;
  logic [CW-1:0] col_nxt;
  logic [RW-1:0] row_r;
  logic [RW-1:0] row_nxt;
  logic [CW-1:0] drn_r;
  logic [CW-1:0] drn_nxt;

  // accept stage
  logic          acc;
  logic          is_pix;
  logic          pix_ok;
  logic          drn_ok;
  logic          go;
  logic          col_last;
  logic          drn_last;
  logic [CW-1:0] rd_addr;
  emit_meta_t    meta;

  // line buffer, each entry holds {row above, middle row}
  logic [LINE_W-1:0] lbuf [MAX_SIZE];
  logic [LINE_W-1:0] rdata_r;

  // read-data stage
  logic          s1_v_r;
  logic          s1_drain_r;
  pix_t          s1_pix_r;
  logic [CW-1:0] s1_addr_r;
  emit_meta_t    s1_meta_r;
  pix_t          rd_above;
  pix_t          rd_mid;
  logic          wb_en;

  // window stage
  window_t       window_r;
  logic          s2_v_r;
  emit_meta_t    s2_meta_r;

  push_t             push;
  logic [LVL_W-1:0]  level;
  logic [1:0]        inflight;
  logic [LVL_W:0]    reserve;

  // ---- configuration ----
  assign cfg_ch.ready = rst_n;
  assign cfg_xfer     = cfg_ch.valid && cfg_ch.ready;
  assign cfg_ext      = EW'(cfg_ch.image_size);

  // clamp the written size to the supported range
  always_comb begin
    if (cfg_ext < EW'(MIN_SIZE)) begin
      size_nxt = RW'(MIN_SIZE);
    end else if (cfg_ext > EW'(MAX_SIZE)) begin
      size_nxt = RW'(MAX_SIZE);
    end else begin
      size_nxt = RW'(cfg_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r    <= RW'(CFG_RESET);
      size_m1_r <= RW'(CFG_RESET - 1);
    end else if (cfg_xfer) begin
      size_r    <= size_nxt;
      size_m1_r <= size_nxt - RW'(1);
    end
  end

  // ---- accept decode ----
  assign inflight    = 2'(s1_v_r) + 2'(s2_v_r) + 2'(push.busy);
  assign reserve     = (LVL_W + 1)'(level) + (LVL_W + 1)'({inflight, 1'b0});
  assign in_ch.ready = rst_n && (reserve <= (LVL_W + 1)'(OFIFO_DEPTH - 2));

  assign acc      = in_ch.valid && in_ch.ready;
  assign is_pix   = (in_ch.opcode == OP_PIXEL);
  assign col_last = (RW'(col_r) == size_m1_r);
  assign drn_last = (RW'(drn_r) == size_m1_r);
  assign pix_ok   = is_pix && (row_r < size_r) && (RW'(col_r) < size_r);
  assign drn_ok   = !is_pix && (row_r == size_r) && (RW'(drn_r) < size_r);
  assign go       = acc && (pix_ok || drn_ok);
  assign rd_addr  = is_pix ? col_r : drn_r;

  // which results this item makes, nothing for the top row of pixels
  always_comb begin
    if (is_pix) begin
      meta.emit_a  = (row_r != '0) && (col_r != '0);
      meta.emit_b  = (row_r != '0) && col_last;
      meta.x_first = (col_r == CW'(1));
      meta.y_first = (row_r == RW'(1));
      meta.y_last  = 1'b0;
    end else begin
      meta.emit_a  = (drn_r != '0);
      meta.emit_b  = drn_last;
      meta.x_first = (drn_r == CW'(1));
      meta.y_first = 1'b0;
      meta.y_last  = 1'b1;
    end
  end

  // column, row and drain counters
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    drn_nxt = drn_r;
    if (cfg_xfer) begin
      col_nxt = '0;
      row_nxt = '0;
      drn_nxt = '0;
    end else if (go && is_pix) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end else if (go) begin
      if (drn_last) begin
        col_nxt = '0;
        row_nxt = '0;
        drn_nxt = '0;
      end else begin
        drn_nxt = drn_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      drn_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      drn_r <= drn_nxt;
    end
  end

  // ---- line buffer: read on transfer, write back in the next cycle ----
  // consecutive items never touch the same column, and a column comes back
  // at least two items later, after its write has landed
  assign rd_above = rdata_r[LINE_W-1 -: PIX_W];
  assign rd_mid   = rdata_r[PIX_W-1:0];
  assign wb_en    = s1_v_r && !s1_drain_r;

  always_ff @(posedge clk) begin
    if (go) begin
      rdata_r <= lbuf[rd_addr];
    end
    if (wb_en) begin
      lbuf[s1_addr_r] <= {rd_mid, s1_pix_r};
    end
  end

  // read-data stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s1_drain_r <= !is_pix;
      s1_pix_r   <= in_ch.pixel_in;
      s1_addr_r  <= rd_addr;
      s1_meta_r  <= meta;
    end
  end

  // ---- window shift; drain repeats the middle row as the bottom ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= '0;
      s2_v_r    <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
      if (s1_v_r) begin
        window_r[0]    <= window_r[1];
        window_r[1]    <= window_r[2];
        window_r[2][0] <= rd_above;
        window_r[2][1] <= rd_mid;
        window_r[2][2] <= s1_drain_r ? rd_mid : s1_pix_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_meta_r <= s1_meta_r;
    end
  end

  // ---- filter and result queue ----
  gblur_kernel u_kernel (
    .clk      (clk),
    .rst_n    (rst_n),
    .win_vld  (s2_v_r),
    .win_meta (s2_meta_r),
    .window   (window_r),
    .push     (push)
  );

  gblur_ofifo u_ofifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .level  (level),
    .out_ch (out_ch)
  );

endmodule

### design/gblur_kernel.sv
// ---------------------------------------------------------------------------
// gblur_kernel
// Tap sums over the window, registered, then shift or divide by nine.
// ---------------------------------------------------------------------------
module gblur_kernel import gblur_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       win_vld,
  input  emit_meta_t win_meta,
  input  window_t    window,
  output push_t      push
);

  logic       s3_v_r;
  emit_meta_t s3_meta_r;
  tap_t       tap_a_r;
  tap_t       tap_b_r;

  logic [PROD_W-1:0] prod_a;
  logic [PROD_W-1:0] prod_b;
  pix_t              val_a;
  pix_t              val_b;
  result_t           res_a;
  result_t           res_b;

  // sum stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= win_vld;
    end
  end

  // tap sums for both candidate centres
  always_ff @(posedge clk) begin
    if (win_vld) begin
      s3_meta_r <= win_meta;
      tap_a_r   <= tap_sum(window, 2'd1, win_meta.x_first, 1'b0,
                           win_meta.y_first, win_meta.y_last);
      tap_b_r   <= tap_sum(window, 2'd2, 1'b0, 1'b1,
                           win_meta.y_first, win_meta.y_last);
    end
  end

  // normalize: shift by four, or reciprocal multiply on corners
  assign prod_a = PROD_W'(tap_a_r.sum) * PROD_W'(DIV9_RECIP);
  assign prod_b = PROD_W'(tap_b_r.sum) * PROD_W'(DIV9_RECIP);
  assign val_a  = tap_a_r.corner ? prod_a[DIV9_SHIFT +: PIX_W] : tap_a_r.sum[SUM_W-1 -: PIX_W];
  assign val_b  = tap_b_r.corner ? prod_b[DIV9_SHIFT +: PIX_W] : tap_b_r.sum[SUM_W-1 -: PIX_W];

  always_comb begin
    res_a.pixel_out = val_a;
    res_a.row_end   = 1'b0;
    res_a.frame_end = 1'b0;
    res_a.run_last  = !s3_meta_r.emit_b;
    res_b.pixel_out = val_b;
    res_b.row_end   = 1'b1;
    res_b.frame_end = s3_meta_r.y_last;
    res_b.run_last  = 1'b1;
  end

  // results in order for the queue
  always_comb begin
    push.busy   = s3_v_r;
    push.cnt    = s3_v_r ? (2'(s3_meta_r.emit_a) + 2'(s3_meta_r.emit_b)) : 2'd0;
    push.first  = s3_meta_r.emit_a ? res_a : res_b;
    push.second = res_b;
  end

endmodule

### design/gblur_ofifo.sv
// ---------------------------------------------------------------------------
// gblur_ofifo
// Result queue, up to two writes a cycle, drives the result channel.
// ---------------------------------------------------------------------------
module gblur_ofifo import gblur_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  push_t              push,
  output logic [LVL_W-1:0]   level,
  gblur_out_if.source        out_ch
);

  result_t            q_r [OFIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_nxt;
  logic [LVL_W-1:0]   cnt_r;
  logic [LVL_W-1:0]   cnt_nxt;
  logic               pop;
  result_t            head;

  assign pop  = out_ch.valid && out_ch.ready;
  assign head = q_r[rd_ptr_r];

  // pointer and fill updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push.cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + LVL_W'(push.cnt) - LVL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage writes
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      q_r[wr_ptr_r] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      q_r[FIFO_AW'(wr_ptr_r + FIFO_AW'(1))] <= push.second;
    end
  end

  assign level            = cnt_r;
  assign out_ch.valid     = (cnt_r != '0);
  assign out_ch.pixel_out = head.pixel_out;
  assign out_ch.row_end   = head.row_end;
  assign out_ch.frame_end = head.frame_end;
  assign out_ch.run_last  = head.run_last;

endmodule

### design/gblur_chk.sv
// ---------------------------------------------------------------------------
// gblur_chk
// Port-level checks on the blur stream, bound to the top level.
// ---------------------------------------------------------------------------
module gblur_chk import gblur_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input pix_t out_pixel,
  input logic out_row_end,
  input logic out_frame_end,
  input logic out_run_last
);

  // queue comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a newly shown result traces back to an earlier input transfer
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 4))
    else $error("result without an input transfer four cycles earlier");

  // the final pixel closes its row and its item
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_row_end && out_run_last)
    else $error("frame end without row end and run last");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid
      && $stable({out_pixel, out_row_end, out_frame_end, out_run_last}))
    else $error("result changed while stalled");

endmodule

bind gaussian_blur_3x3_stream gblur_chk u_gblur_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_pixel     (out_ch.pixel_out),
  .out_row_end   (out_ch.row_end),
  .out_frame_end (out_ch.frame_end),
  .out_run_last  (out_ch.run_last)
);
